// File: rtl/owik_pkg.sv
// Shared types and constants of the omni wheel inverse kinematics block.
// Holds the CORDIC table, the wheel geometry rows and the payload widths.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package owik_pkg;

    // Payload widths.
    localparam int SPEED_W  = 16;
    localparam int HEAD_W   = 16;
    localparam int RADIUS_W = 16;
    localparam int WHEEL_W  = 18;
    localparam int WHEELS   = 4;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd5898;

    // CORDIC: 16 rotations on 32-bit values, angle unit 2^32 per turn.
    localparam int CORDIC_ITERS               = 16;
    localparam int CORDIC_ITER_PER_STAGE_DEF  = 2;
    localparam int CORDIC_W                   = 32;
    localparam int RESID_W                    = 14;

    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 32'sd652032874;

    localparam logic signed [CORDIC_W-1:0] ATAN_TAB [CORDIC_ITERS] = '{
        32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
        32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
        32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
        32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA, 32'sh0000517D
    };

    // Quadrant codes taken from the top two heading bits.
    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;
    localparam logic [1:0] QUAD_FOURTH = 2'd3;

    // Sine and cosine in Q2.14.
    localparam int TRIG_W = 16;
    localparam logic signed [TRIG_W:0] TRIG_ONE = 17'sd16384;

    // Robot-frame speeds (Q.22), angular term (Q.24), wheel sums (Q.36).
    localparam int UV_W   = 32;
    localparam int W_W    = 33;
    localparam int ACC_W  = 48;
    localparam int W_SHIFT   = 12;
    localparam int RND_SHIFT = 28;
    localparam int RND_W     = ACC_W - RND_SHIFT;

    localparam logic signed [RND_W-1:0] WHEEL_MAX = 20'sd131071;
    localparam logic signed [RND_W-1:0] WHEEL_MIN = -20'sd131072;

    // Geometry rows in Q1.14; the angular weight of every wheel is 1.0.
    localparam int COEF_W = 16;
    localparam logic signed [COEF_W-1:0] COEF_U [WHEELS] = '{
        -16'sd8923, -16'sd8923, 16'sd11585, 16'sd11585
    };
    localparam logic signed [COEF_W-1:0] COEF_V [WHEELS] = '{
        16'sd13741, -16'sd13741, -16'sd11585, 16'sd11585
    };

    // Side data that rides along with the heading through the CORDIC.
    typedef struct packed {
        logic signed [SPEED_W-1:0] vx;
        logic signed [SPEED_W-1:0] vy;
        logic [1:0]                quad;
        logic signed [W_W-1:0]     w;
    } owik_tag_t;

endpackage

// File: rtl/owik_cordic.sv
// Pipelined rotation-mode CORDIC producing cosine and sine of a quadrant residual.
// Several rotations per register stage; a side tag travels with each item.
// Depends on owik_pkg.
`timescale 1ns / 1ps

module owik_cordic
    import owik_pkg::*;
#(
    parameter int ITER_PER_STAGE = CORDIC_ITER_PER_STAGE_DEF
)
(
    input  logic                                       clk,
    input  logic [CORDIC_ITERS/ITER_PER_STAGE-1:0]     en,
    input  logic [RESID_W-1:0]                         residual,
    input  owik_tag_t                                  tag_in,
    output logic signed [CORDIC_W-1:0]                 x_out,
    output logic signed [CORDIC_W-1:0]                 y_out,
    output owik_tag_t                                  tag_out
);

    localparam int STAGES = CORDIC_ITERS / ITER_PER_STAGE;

    logic signed [CORDIC_W-1:0] x_reg [STAGES];
    logic signed [CORDIC_W-1:0] y_reg [STAGES];
    logic signed [CORDIC_W-1:0] z_reg [STAGES];
    owik_tag_t                  tag_reg [STAGES];

    logic signed [CORDIC_W-1:0] x_next [STAGES];
    logic signed [CORDIC_W-1:0] y_next [STAGES];
    logic signed [CORDIC_W-1:0] z_next [STAGES];
    owik_tag_t                  tag_next [STAGES];

    // Values entering each stage: the start vector for the first, the previous
    // stage's registers for the rest.
    logic signed [CORDIC_W-1:0] x_feed [STAGES];
    logic signed [CORDIC_W-1:0] y_feed [STAGES];
    logic signed [CORDIC_W-1:0] z_feed [STAGES];
    owik_tag_t                  tag_feed [STAGES];

    genvar s;
    generate
        for (s = 0; s < STAGES; s++)
        begin : g_stage
            if (s == 0)
            begin : g_first
                assign x_feed[s]   = CORDIC_X0;
                assign y_feed[s]   = '0;
                assign z_feed[s]   = $signed({2'b00, residual, 16'b0});
                assign tag_feed[s] = tag_in;
            end
            else
            begin : g_chain
                assign x_feed[s]   = x_reg[s-1];
                assign y_feed[s]   = y_reg[s-1];
                assign z_feed[s]   = z_reg[s-1];
                assign tag_feed[s] = tag_reg[s-1];
            end

            always_comb
            begin
                logic signed [CORDIC_W-1:0] xc;
                logic signed [CORDIC_W-1:0] yc;
                logic signed [CORDIC_W-1:0] zc;
                logic signed [CORDIC_W-1:0] dx;
                logic signed [CORDIC_W-1:0] dy;
                xc = x_feed[s];
                yc = y_feed[s];
                zc = z_feed[s];
                tag_next[s] = tag_feed[s];
                for (int j = 0; j < ITER_PER_STAGE; j++)
                begin
                    dx = yc >>> (s * ITER_PER_STAGE + j);
                    dy = xc >>> (s * ITER_PER_STAGE + j);
                    if (!zc[CORDIC_W-1])
                    begin
                        xc = xc - dx;
                        yc = yc + dy;
                        zc = zc - ATAN_TAB[s * ITER_PER_STAGE + j];
                    end
                    else
                    begin
                        xc = xc + dx;
                        yc = yc - dy;
                        zc = zc + ATAN_TAB[s * ITER_PER_STAGE + j];
                    end
                end
                x_next[s] = xc;
                y_next[s] = yc;
                z_next[s] = zc;
            end

            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    x_reg[s]   <= x_next[s];
                    y_reg[s]   <= y_next[s];
                    z_reg[s]   <= z_next[s];
                    tag_reg[s] <= tag_next[s];
                end
            end
        end
    endgenerate

    assign x_out   = x_reg[STAGES-1];
    assign y_out   = y_reg[STAGES-1];
    assign tag_out = tag_reg[STAGES-1];

endmodule

// File: rtl/omni_wheel_inverse_kinematics.sv
// Top level of the four-wheel omnidirectional inverse kinematics pipeline.
// Uses owik_pkg for types and constants and owik_cordic for sine and cosine.
`timescale 1ns / 1ps

// This block turns a field-frame velocity command into four wheel speeds. Each input
// item carries vx, vy (Q8.8 m/s), a turn rate (Q8.8 rad/s) and a heading (65536 per
// turn); each result item carries four Q10.8 wheel speeds, saturated to 18 bits. The
// heading is split into a quadrant and a residual angle, the residual goes through a
// pipelined 16-rotation CORDIC, and the rounded cosine and sine rotate the velocity into
// the robot frame. The turn rate is scaled by the body radius register, and each wheel
// speed is a fixed dot product with its geometry row, rounded to nearest and clamped.
// The pipeline takes one item per clock unless a blocked output has filled every stage,
// and holds no state between items. After the CORDIC, registered stages round and unfold
// the cosine and sine, rotate the velocity, form the geometry products and wheel sums,
// and hold the result. Each stage has its own valid bit and advances when the next stage
// is empty or moving, so a stalled output only holds up as many items as the pipeline
// holds, and empty stages keep filling behind it. The body radius register may only be
// written while no item is in flight; writes are always taken (cfg_ready is high).

module omni_wheel_inverse_kinematics
    import owik_pkg::*;
#(
    parameter int CORDIC_ITER_PER_STAGE = CORDIC_ITER_PER_STAGE_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    // Configuration write: body_radius, unsigned Q0.16 meters.
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [RADIUS_W-1:0] cfg_data,
    // Input items.
    input  logic                s_tvalid,
    output logic                s_tready,
    // From bit 0 up: field_speed_x, field_speed_y, turn_rate, heading (16 bits each).
    input  logic [63:0]         s_tdata,
    // Result items.
    output logic                m_tvalid,
    input  logic                m_tready,
    // From bit 0 up: wheel_one_speed, wheel_two_speed, wheel_three_speed,
    // wheel_four_speed (18 bits each).
    output logic [71:0]         m_tdata
);

    localparam int CSTAGES = CORDIC_ITERS / CORDIC_ITER_PER_STAGE;
    localparam int ST_TRIG = CSTAGES;
    localparam int ST_PROD = CSTAGES + 1;
    localparam int ST_UV   = CSTAGES + 2;
    localparam int ST_COEF = CSTAGES + 3;
    localparam int ST_SUM  = CSTAGES + 4;
    localparam int ST_OUT  = CSTAGES + 5;
    localparam int NSTAGE  = CSTAGES + 6;

    // Rounds a CORDIC output to Q2.14 and clamps it to plus or minus one.
    function automatic logic signed [TRIG_W-1:0] round_q14(logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_W:0] t;
        logic signed [TRIG_W:0]   q;
        t = $signed({v[CORDIC_W-1], v}) + 33'sd32768;
        q = t[CORDIC_W:CORDIC_W-TRIG_W];
        if (q > TRIG_ONE)
            q = TRIG_ONE;
        else if (q < -TRIG_ONE)
            q = -TRIG_ONE;
        return q[TRIG_W-1:0];
    endfunction

    // Configuration register.
    logic [RADIUS_W-1:0] body_radius_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            body_radius_reg <= RADIUS_RESET;
        else if (cfg_valid && cfg_ready)
            body_radius_reg <= cfg_data;
    end

    // Stage valid bits and the advance chain: a stage loads when it is empty
    // or when the stage after it loads in the same cycle.
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] en;

    always_comb
    begin
        en[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_tready;
        for (int k = NSTAGE - 2; k >= 0; k--)
            en[k] = !valid_reg[k] || en[k+1];
    end

    always_comb
    begin
        valid_next[0] = en[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < NSTAGE; k++)
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[ST_OUT];

    // Input unpacking; the angular term is formed alongside the first CORDIC stage.
    logic signed [SPEED_W-1:0] in_vx;
    logic signed [SPEED_W-1:0] in_vy;
    logic signed [SPEED_W-1:0] in_tr;
    logic [HEAD_W-1:0]         in_head;
    owik_tag_t                 in_tag;

    assign in_vx   = s_tdata[15:0];
    assign in_vy   = s_tdata[31:16];
    assign in_tr   = s_tdata[47:32];
    assign in_head = s_tdata[63:48];

    always_comb
    begin
        in_tag.vx   = in_vx;
        in_tag.vy   = in_vy;
        in_tag.quad = in_head[HEAD_W-1:HEAD_W-2];
        in_tag.w    = W_W'(in_tr) * W_W'($signed({1'b0, body_radius_reg}));
    end

    logic signed [CORDIC_W-1:0] cx;
    logic signed [CORDIC_W-1:0] cy;
    owik_tag_t                  ctag;

    owik_cordic #(
        .ITER_PER_STAGE (CORDIC_ITER_PER_STAGE)
    ) u_cordic (
        .clk      (clk),
        .en       (en[CSTAGES-1:0]),
        .residual (in_head[RESID_W-1:0]),
        .tag_in   (in_tag),
        .x_out    (cx),
        .y_out    (cy),
        .tag_out  (ctag)
    );

    // Rounding and quadrant unfolding.
    logic signed [TRIG_W-1:0] c0;
    logic signed [TRIG_W-1:0] s0;
    logic signed [TRIG_W-1:0] cs_next;
    logic signed [TRIG_W-1:0] sn_next;
    logic signed [TRIG_W-1:0] cs_reg;
    logic signed [TRIG_W-1:0] sn_reg;
    owik_tag_t                tag_trig_reg;

    always_comb
    begin
        c0 = round_q14(cx);
        s0 = round_q14(cy);
        case (ctag.quad)
            QUAD_FIRST:
            begin
                cs_next = c0;
                sn_next = s0;
            end
            QUAD_SECOND:
            begin
                cs_next = -s0;
                sn_next = c0;
            end
            QUAD_THIRD:
            begin
                cs_next = -c0;
                sn_next = -s0;
            end
            default:
            begin
                cs_next = s0;
                sn_next = -c0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_TRIG])
        begin
            cs_reg       <= cs_next;
            sn_reg       <= sn_next;
            tag_trig_reg <= ctag;
        end
    end

    // Rotation products.
    logic signed [UV_W-1:0] p_xc_reg;
    logic signed [UV_W-1:0] p_ys_reg;
    logic signed [UV_W-1:0] p_yc_reg;
    logic signed [UV_W-1:0] p_xs_reg;
    owik_tag_t              tag_prod_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_PROD])
        begin
            p_xc_reg     <= UV_W'(tag_trig_reg.vx) * UV_W'(cs_reg);
            p_ys_reg     <= UV_W'(tag_trig_reg.vy) * UV_W'(sn_reg);
            p_yc_reg     <= UV_W'(tag_trig_reg.vy) * UV_W'(cs_reg);
            p_xs_reg     <= UV_W'(tag_trig_reg.vx) * UV_W'(sn_reg);
            tag_prod_reg <= tag_trig_reg;
        end
    end

    // Robot-frame speeds u and v.
    logic signed [UV_W-1:0] u_reg;
    logic signed [UV_W-1:0] v_reg;
    logic signed [W_W-1:0]  w_uv_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_UV])
        begin
            u_reg    <= p_xc_reg + p_ys_reg;
            v_reg    <= p_yc_reg - p_xs_reg;
            w_uv_reg <= tag_prod_reg.w;
        end
    end

    // Geometry products, one pair per wheel, and the shared angular term.
    logic signed [ACC_W-1:0] mu_reg [WHEELS];
    logic signed [ACC_W-1:0] mv_reg [WHEELS];
    logic signed [ACC_W-1:0] wsh_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_COEF])
        begin
            for (int k = 0; k < WHEELS; k++)
            begin
                mu_reg[k] <= ACC_W'(COEF_U[k]) * ACC_W'(u_reg);
                mv_reg[k] <= ACC_W'(COEF_V[k]) * ACC_W'(v_reg);
            end
            wsh_reg <= ACC_W'(w_uv_reg) <<< W_SHIFT;
        end
    end

    // Wheel sums in Q.36.
    logic signed [ACC_W-1:0] acc_reg [WHEELS];

    always_ff @(posedge clk)
    begin
        if (en[ST_SUM])
        begin
            for (int k = 0; k < WHEELS; k++)
                acc_reg[k] <= mu_reg[k] + mv_reg[k] + wsh_reg;
        end
    end

    // Round to Q10.8 and saturate.
    logic signed [WHEEL_W-1:0] wheel_next [WHEELS];
    logic signed [WHEEL_W-1:0] wheel_reg  [WHEELS];

    always_comb
    begin
        logic signed [ACC_W-1:0] t;
        logic signed [RND_W-1:0] r;
        for (int k = 0; k < WHEELS; k++)
        begin
            t = acc_reg[k] + (ACC_W'(1) <<< (RND_SHIFT - 1));
            r = t[ACC_W-1:RND_SHIFT];
            if (r > WHEEL_MAX)
                r = WHEEL_MAX;
            else if (r < WHEEL_MIN)
                r = WHEEL_MIN;
            wheel_next[k] = r[WHEEL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            for (int k = 0; k < WHEELS; k++)
                wheel_reg[k] <= wheel_next[k];
        end
    end

    assign m_tdata = {wheel_reg[3], wheel_reg[2], wheel_reg[1], wheel_reg[0]};

    // The input side only stalls when every stage is full and the output is blocked.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&valid_reg) && !m_tready)
        else $error("input stalled while the pipeline had an empty stage");

    // An accepted item occupies the first stage on the next cycle.
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> valid_reg[0])
        else $error("accepted item did not enter the first stage");

    // An item ahead of an empty output register moves into it.
    a_output_fills: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ST_SUM] && !m_tvalid |=> m_tvalid)
        else $error("item did not advance into an empty output register");

    // A delivered result is followed by another only if the stage before held one.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !valid_reg[ST_SUM] |=> !m_tvalid)
        else $error("result appeared without an item behind it");

endmodule
